// ===== hdl/ias_pkg.sv =====
// ----------------------------------------------------------------------------
// ias_pkg
// Shared types and codes for the inactive aging scheduler.
// ----------------------------------------------------------------------------
package ias_pkg;

  // Request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;  // unknown request, no effect

  // Slot state codes
  localparam logic [1:0] SLOT_UNUSED  = 2'd0;
  localparam logic [1:0] SLOT_READY   = 2'd1;
  localparam logic [1:0] SLOT_RUNNING = 2'd2;
  localparam logic [1:0] SLOT_BLOCKED = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] slot_id;
    logic [1:0] slot_state;
    logic [7:0] slot_priority;
    logic       clear_age;
    logic [2:0] current_slot;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] next_slot;
    logic       chosen_valid;
  } out_beat_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_EXEC,
    CS_SCAN,
    CS_FIN,
    CS_RESULT
  } ctrl_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;     // latch request beat, reset scan
    logic do_write;   // write one slot entry
    logic do_clear;   // zero all ages
    logic do_wake;    // tick with no ready slot
    logic scan_step;  // age one slot and compare
    logic finish;     // clear winner age, wake blocked current
    logic emit;       // load output register
  } ias_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       none_ready;
    logic       scan_last;
    logic       out_free;
    logic       have_best;
  } ias_sts_t;

endpackage

// ===== hdl/ias_ctrl.sv =====
// ----------------------------------------------------------------------------
// ias_ctrl
// Sequencer: accept, decode, slot scan, finish, result hand-off.
// ----------------------------------------------------------------------------
module ias_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ias_pkg::ias_sts_t sts,
  output ias_pkg::ias_cmd_t cmd
);

  ias_pkg::ctrl_state_t state_r;
  ias_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ias_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ias_pkg::CS_IDLE: begin
        // no beat is taken while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.accept = 1'b1;
          state_nxt  = ias_pkg::CS_EXEC;
        end
      end
      ias_pkg::CS_EXEC: begin
        state_nxt = ias_pkg::CS_RESULT;
        unique case (sts.req_type)
          ias_pkg::REQ_WRITE: cmd.do_write = 1'b1;
          ias_pkg::REQ_CLEAR: cmd.do_clear = 1'b1;
          ias_pkg::REQ_TICK: begin
            if (sts.none_ready) begin
              cmd.do_wake = 1'b1;
            end else begin
              state_nxt = ias_pkg::CS_SCAN;
            end
          end
          default: ;  // unknown request: no change, zero result
        endcase
      end
      ias_pkg::CS_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ias_pkg::CS_FIN;
        end
      end
      ias_pkg::CS_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ias_pkg::CS_RESULT;
      end
      ias_pkg::CS_RESULT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ias_pkg::CS_IDLE;
        end
      end
      default: state_nxt = ias_pkg::CS_IDLE;
    endcase
  end

endmodule

// ===== hdl/ias_dpath.sv =====
// ----------------------------------------------------------------------------
// ias_dpath
// Slot table, ready counter, scan compare and output register.
// ----------------------------------------------------------------------------
module ias_dpath #(
  parameter int NUM_SLOTS = 8,
  parameter int AGE_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ias_pkg::in_beat_t   in_data,
  input  logic                out_ready,
  output logic                out_valid,
  output ias_pkg::out_beat_t  out_data,
  input  ias_pkg::ias_cmd_t   cmd,
  output ias_pkg::ias_sts_t   sts
);

  localparam int IDX_W = $clog2(NUM_SLOTS);

  logic [1:0]          state_r [NUM_SLOTS];
  logic [7:0]          prio_r  [NUM_SLOTS];
  logic [AGE_BITS-1:0] age_r   [NUM_SLOTS];

  logic [IDX_W-1:0]    ready_cnt_r;
  ias_pkg::in_beat_t   req_r;
  logic [IDX_W-1:0]    idx_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic [AGE_BITS-1:0] best_age_r;
  logic [7:0]          best_prio_r;
  logic                have_r;
  ias_pkg::out_beat_t  res_r;
  logic                out_valid_r;
  ias_pkg::out_beat_t  out_data_r;

  // Slot indexes from 3-bit fields, sized to the table
  logic [IDX_W+2:0] id_ext, cur_ext;
  logic [IDX_W-1:0] id_idx, cur_idx;
  logic             id_ok, cur_ok, cur_blocked;
  logic             new_ready, old_ready;
  logic [AGE_BITS-1:0] aged;
  logic             elig, better;
  logic [IDX_W+2:0] best_ext;

  assign id_ext  = {{IDX_W{1'b0}}, req_r.slot_id};
  assign cur_ext = {{IDX_W{1'b0}}, req_r.current_slot};
  assign id_idx  = id_ext[IDX_W-1:0];
  assign cur_idx = cur_ext[IDX_W-1:0];
  assign id_ok   = ({29'd0, req_r.slot_id} < NUM_SLOTS);
  assign cur_ok  = ({29'd0, req_r.current_slot} < NUM_SLOTS);
  assign cur_blocked = cur_ok && (state_r[cur_idx] == ias_pkg::SLOT_BLOCKED);

  assign new_ready = (req_r.slot_state == ias_pkg::SLOT_READY);
  assign old_ready = (state_r[id_idx] == ias_pkg::SLOT_READY);

  assign aged   = age_r[idx_r] + AGE_BITS'(prio_r[idx_r]);
  assign elig   = (state_r[idx_r] == ias_pkg::SLOT_READY) ||
                  (state_r[idx_r] == ias_pkg::SLOT_RUNNING);
  assign better = !have_r || (aged > best_age_r) ||
                  ((aged == best_age_r) && (prio_r[idx_r] > best_prio_r));
  assign best_ext = {3'b000, best_idx_r};

  // Table and ready count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        state_r[i] <= ias_pkg::SLOT_UNUSED;
        prio_r[i]  <= '0;
        age_r[i]   <= '0;
      end
      ready_cnt_r <= '0;
    end else begin
      priority if (cmd.do_write) begin
        if (id_ok) begin
          state_r[id_idx] <= req_r.slot_state;
          prio_r[id_idx]  <= req_r.slot_priority;
          if (req_r.clear_age) begin
            age_r[id_idx] <= '0;
          end
          if (id_idx != '0) begin
            if (new_ready && !old_ready) begin
              ready_cnt_r <= ready_cnt_r + 1'b1;
            end else if (!new_ready && old_ready) begin
              ready_cnt_r <= ready_cnt_r - 1'b1;
            end
          end
        end
      end else if (cmd.do_clear) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          age_r[i] <= '0;
        end
      end else if (cmd.do_wake) begin
        if (cur_blocked) begin
          state_r[cur_idx] <= ias_pkg::SLOT_READY;
          age_r[cur_idx]   <= '0;
          if (cur_idx != '0) begin
            ready_cnt_r <= ready_cnt_r + 1'b1;
          end
        end
      end else if (cmd.scan_step) begin
        age_r[idx_r] <= aged;
      end else if (cmd.finish) begin
        age_r[best_idx_r] <= '0;
        if (cur_blocked) begin
          state_r[cur_idx] <= ias_pkg::SLOT_READY;
          if (cur_idx != '0) begin
            ready_cnt_r <= ready_cnt_r + 1'b1;
          end
        end
      end
    end
  end

  // Request, scan and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        req_r  <= in_data;
        idx_r  <= IDX_W'(1);
        have_r <= 1'b0;
        res_r  <= '0;
      end
      if (cmd.do_wake) begin
        res_r.next_slot    <= cur_blocked ? req_r.current_slot : 3'd0;
        res_r.chosen_valid <= 1'b1;
      end
      if (cmd.scan_step) begin
        idx_r <= idx_r + 1'b1;
        if (elig && better) begin
          have_r      <= 1'b1;
          best_idx_r  <= idx_r;
          best_age_r  <= aged;
          best_prio_r <= prio_r[idx_r];
        end
      end
      if (cmd.finish) begin
        res_r.next_slot    <= best_ext[2:0];
        res_r.chosen_valid <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.req_type   = req_r.req_type;
  assign sts.none_ready = (ready_cnt_r == '0);
  assign sts.scan_last  = (idx_r == IDX_W'(NUM_SLOTS - 1));
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.have_best  = have_r;

endmodule

// ===== hdl/inactive_aging_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// inactive_aging_scheduler_unit
// Aging priority scheduler over a table of process slots.
// ----------------------------------------------------------------------------
// Sequence: accept, then EXEC; write, clear and unknown beats and a tick with no
//   ready slot go on to RESULT, a scanning tick goes through SCAN and FIN first;
//   RESULT loads the output register once it is free.
// One beat at a time: the next beat is taken once the result is in the output
//   register (which may still be waiting on out_ready).
// The scan ages and compares one slot per cycle through a shared adder.
// Reset (rst_n low, synchronous): all slots unused, priorities and ages zero.
// ----------------------------------------------------------------------------
module inactive_aging_scheduler_unit #(
  parameter int NUM_SLOTS = 8,
  parameter int AGE_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ias_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ias_pkg::out_beat_t out_data
);

  // Command and status between sequencer and datapath
  ias_pkg::ias_cmd_t cmd;
  ias_pkg::ias_sts_t sts;

  // Sequencer: IDLE takes a beat, EXEC decodes it, SCAN walks slots
  // 1..NUM_SLOTS-1, FIN clears the winner, RESULT hands off the beat.
  ias_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: slot table, a running count of ready slots other than slot 0 (so a
  // tick knows at once whether to scan), the compare registers and the output beat.
  ias_dpath #(
    .NUM_SLOTS (NUM_SLOTS),
    .AGE_BITS  (AGE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // in_ready is low right after a beat is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready held right after accept");

  // Non-tick results never name a slot
  a_zero_slot_on_non_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.chosen_valid |-> out_data.next_slot == 3'd0)
    else $error("slot reported on non-tick beat");

  // A scan that was started must have found an eligible slot
  a_winner_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.have_best)
    else $error("scan finished without a winner");

endmodule
